// File: src/iirdf_pkg.sv
// Shared types, constants and the microcode program of the direct form I IIR filter.
package iirdf_pkg;

  localparam int ORDER_W  = 5;
  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 5;
  localparam int COEF_W   = 32;
  localparam int HIST_W   = 32;
  localparam int ACC_W    = 64;
  localparam int YFULL_W  = ACC_W - 24;
  localparam int HFULL_W  = ACC_W - 16;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd2;

  // Half an output LSB for the two roundings (Q.24 to integer, Q.24 to Q.8).
  localparam logic signed [ACC_W-1:0] RND_Y = 64'sh0000_0000_0080_0000;
  localparam logic signed [ACC_W-1:0] RND_H = 64'sh0000_0000_0000_8000;

  typedef enum logic [1:0] {
    ACT_FILTER = 2'd0,
    ACT_WR_NUM = 2'd1,
    ACT_WR_DEN = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Operand selection of the shared multiplier; also tags the product.
  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_B_X    = 2'd1,
    MUL_B_HIST = 2'd2,
    MUL_A_HIST = 2'd3
  } mul_sel_e;

  typedef enum logic [2:0] {
    COND_NONE       = 3'd0,
    COND_NO_FILTER  = 3'd1,
    COND_ORDER_ZERO = 3'd2,
    COND_TAP_MORE   = 3'd3,
    COND_OUT_BUSY   = 3'd4
  } cond_e;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_B0    = 3'd1;
  localparam step_t STEP_TAP_B = 3'd2;
  localparam step_t STEP_TAP_A = 3'd3;
  localparam step_t STEP_DRAIN = 3'd4;
  localparam step_t STEP_ROUND = 3'd5;
  localparam step_t STEP_EMIT  = 3'd6;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     tap_clr;
    logic     tap_inc;
    logic     round;
    logic     emit;
    logic     wrap;
    cond_e    cond;
    step_t    target;
  } ucode_t;

  // The control program. A step jumps to target when its condition holds,
  // otherwise it moves on to the next step, or back to idle if wrap is set.
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.cond   = COND_NO_FILTER;
        w.target = STEP_IDLE;
      end
      STEP_B0: begin
        w.mul_sel = MUL_B_X;
        w.acc_clr = 1'b1;
        w.tap_clr = 1'b1;
        w.cond    = COND_ORDER_ZERO;
        w.target  = STEP_DRAIN;
      end
      STEP_TAP_B: begin
        w.mul_sel = MUL_B_HIST;
      end
      STEP_TAP_A: begin
        w.mul_sel = MUL_A_HIST;
        w.tap_inc = 1'b1;
        w.cond    = COND_TAP_MORE;
        w.target  = STEP_TAP_B;
      end
      STEP_DRAIN: begin
        w.mul_sel = MUL_NONE;
      end
      STEP_ROUND: begin
        w.round = 1'b1;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.wrap   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: begin
        w.wrap = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/iir_direct_form_filter_core.sv
// Direct form I IIR filter: microcoded sequencer around one shared multiply-accumulate.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------------------
//   s_axis   | in        | tvalid_i / tready_o     | tdata: sample_in, coef_index, coef_value
//            |           |                         | tuser: action, block_start
//   m_axis   | out       | tvalid_o / tready_i     | tdata: sample_out; tuser: saturated
//   cfg      | in        | cfg_valid_i/cfg_ready_o | order_in_use
//
// A coefficient write leaves the sequencer idle. A filter beat keeps the block busy
// from acceptance until its result is emitted, as the single multiplier serves
// the b0 product and then each numerator and denominator tap in a step of its own.
// The result sits in an output register; if that is still occupied when a new
// result is ready, the final step stalls until the downstream side takes it.
// Reset clears the coefficients, both histories, the order (to 2) and all control.
module iir_direct_form_filter_core
  import iirdf_pkg::*;
#(
  parameter int MAX_ORDER = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] sample_in, [20:16] coef_index, [52:21] coef_value, [55:53] zero
  input  logic [55:0] s_axis_tdata_i,
  // [1:0] action, [2] block_start
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] sample_out
  output logic [15:0] m_axis_tdata_o,
  // [0] saturated
  output logic [0:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  // Tap pointer addresses the histories and the denominator store; the count
  // width also covers the numerator store, which is one entry deeper.
  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W = $clog2(MAX_ORDER + 1);

  // Input beat unpacking.
  action_e                    in_action;
  logic                       in_block_start;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [INDEX_W-1:0]         in_coef_index;
  logic signed [COEF_W-1:0]   in_coef_value;
  logic                       in_acc;

  assign in_action      = action_e'(s_axis_tuser_i[1:0]);
  assign in_block_start = s_axis_tuser_i[2];
  assign in_sample      = s_axis_tdata_i[15:0];
  assign in_coef_index  = s_axis_tdata_i[20:16];
  assign in_coef_value  = s_axis_tdata_i[52:21];

  // Sequencer state.
  step_t            step_q, step_d;
  ucode_t           uc;
  logic [IDX_W-1:0] tap_q;
  logic [CNT_W-1:0] n_eff;
  logic             order_zero;
  logic             tap_more;
  logic             cond_true;

  // Configuration.
  logic [ORDER_W-1:0] order_q;

  // Stores and histories.
  logic signed [COEF_W-1:0]   num_q [MAX_ORDER+1];
  logic signed [COEF_W-1:0]   den_q [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] xh_q  [MAX_ORDER];
  logic signed [HIST_W-1:0]   yh_q  [MAX_ORDER];
  logic signed [SAMPLE_W-1:0] x_q;

  logic             num_we, den_we;
  logic [CNT_W-1:0] num_wr_idx;
  logic [IDX_W-1:0] den_wr_idx;
  logic             hist_clr, hist_shift;

  // Datapath.
  logic signed [COEF_W-1:0] op_c;
  logic signed [HIST_W-1:0] op_d;
  logic [CNT_W-1:0]         num_rd_idx;
  logic signed [ACC_W-1:0]  prod_q;
  mul_sel_e                 kind_q;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  sum_y, sum_h;
  logic signed [YFULL_W-1:0] y_full_q;
  logic signed [HFULL_W-1:0] h_full_q;
  logic                     y_sat, h_sat;
  logic signed [SAMPLE_W-1:0] y_clip;
  logic signed [HIST_W-1:0]   h_clip;

  // Output register.
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;
  logic                       out_sat_q;
  logic                       out_free;
  logic                       emit_fire;

  assign s_axis_tready_o = (step_q == STEP_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // ---------------------------------------------------------------------
  // Control program and sequencing
  // ---------------------------------------------------------------------
  assign uc = ucode_rom(step_q);

  // Orders above the store depth behave as the full depth.
  always_comb begin
    if (int'(order_q) > MAX_ORDER) begin
      n_eff = CNT_W'(MAX_ORDER);
    end else begin
      n_eff = CNT_W'(order_q);
    end
  end

  assign order_zero = (n_eff == '0);
  assign tap_more   = ((CNT_W'(tap_q) + CNT_W'(1)) != n_eff);
  assign out_free   = !out_valid_q || m_axis_tready_i;

  always_comb begin
    case (uc.cond)
      COND_NO_FILTER:  cond_true = !(in_acc && (in_action == ACT_FILTER));
      COND_ORDER_ZERO: cond_true = order_zero;
      COND_TAP_MORE:   cond_true = tap_more;
      COND_OUT_BUSY:   cond_true = !out_free;
      default:         cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      step_d = uc.target;
    end else if (uc.wrap) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      tap_q  <= '0;
      kind_q <= MUL_NONE;
    end else begin
      step_q <= step_d;
      kind_q <= uc.mul_sel;
      if (uc.tap_clr) begin
        tap_q <= '0;
      end else if (uc.tap_inc) begin
        tap_q <= tap_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      order_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // Coefficient stores
  // ---------------------------------------------------------------------
  // Out-of-range indices, and denominator index zero (a0 is fixed at one),
  // leave the stores untouched.
  assign num_we = in_acc && (in_action == ACT_WR_NUM) && (int'(in_coef_index) <= MAX_ORDER);
  assign den_we = in_acc && (in_action == ACT_WR_DEN) && (in_coef_index != '0)
                  && (int'(in_coef_index) <= MAX_ORDER);
  assign num_wr_idx = CNT_W'(in_coef_index);
  assign den_wr_idx = IDX_W'(in_coef_index - INDEX_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '{default: '0};
      den_q <= '{default: '0};
    end else begin
      if (num_we) begin
        num_q[num_wr_idx] <= in_coef_value;
      end
      if (den_we) begin
        den_q[den_wr_idx] <= in_coef_value;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Histories: cleared by a block start, shifted once per result
  // ---------------------------------------------------------------------
  assign hist_clr   = in_acc && (in_action == ACT_FILTER) && in_block_start;
  assign emit_fire  = uc.emit && out_free;
  assign hist_shift = emit_fire;

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_action == ACT_FILTER)) begin
      x_q <= in_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh_q <= '{default: '0};
      yh_q <= '{default: '0};
    end else if (hist_clr) begin
      xh_q <= '{default: '0};
      yh_q <= '{default: '0};
    end else if (hist_shift) begin
      for (int i = MAX_ORDER - 1; i > 0; i--) begin
        xh_q[i] <= xh_q[i-1];
        yh_q[i] <= yh_q[i-1];
      end
      xh_q[0] <= x_q;
      yh_q[0] <= h_clip;
    end
  end

  // ---------------------------------------------------------------------
  // Shared multiplier, then the accumulator behind its product register
  // ---------------------------------------------------------------------
  assign num_rd_idx = CNT_W'(tap_q) + CNT_W'(1);

  always_comb begin
    case (uc.mul_sel)
      MUL_B_X: begin
        op_c = num_q[0];
        op_d = HIST_W'(x_q);
      end
      MUL_B_HIST: begin
        op_c = num_q[num_rd_idx];
        op_d = HIST_W'(xh_q[tap_q]);
      end
      MUL_A_HIST: begin
        op_c = den_q[tap_q];
        op_d = yh_q[tap_q];
      end
      default: begin
        op_c = '0;
        op_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ACC_W'(op_c) * ACC_W'(op_d);
  end

  // Feed-forward products are already Q.24; feedback products are Q.32 and
  // are floored to Q.24 before being subtracted.
  always_comb begin
    case (kind_q)
      MUL_B_X, MUL_B_HIST: term = prod_q;
      MUL_A_HIST:          term = -(prod_q >>> 8);
      default:             term = '0;
    endcase
  end

  assign acc_d = uc.acc_clr ? '0 : (acc_q + term);

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // ---------------------------------------------------------------------
  // Rounding (its own step) and saturation (in the emit step)
  assign sum_y = acc_q + RND_Y;
  assign sum_h = acc_q + RND_H;

  always_ff @(posedge clk_i) begin
    if (uc.round) begin
      y_full_q <= sum_y[ACC_W-1:24];
      h_full_q <= sum_h[ACC_W-1:16];
    end
  end

  assign y_sat = !((&y_full_q[YFULL_W-1:SAMPLE_W-1]) || !(|y_full_q[YFULL_W-1:SAMPLE_W-1]));
  assign h_sat = !((&h_full_q[HFULL_W-1:HIST_W-1]) || !(|h_full_q[HFULL_W-1:HIST_W-1]));

  always_comb begin
    if (!y_sat) begin
      y_clip = y_full_q[SAMPLE_W-1:0];
    end else if (y_full_q[YFULL_W-1]) begin
      y_clip = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_clip = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    if (!h_sat) begin
      h_clip = h_full_q[HIST_W-1:0];
    end else if (h_full_q[HFULL_W-1]) begin
      h_clip = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      h_clip = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q <= y_clip;
      out_sat_q  <= y_sat;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_sat_q;

endmodule

// File: src/iirdf_checker.sv
// Port-level assertions for the IIR filter core and the bind that attaches them.
module iirdf_checker
  import iirdf_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A result that is not taken stays offered with the same value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // A filter beat occupies the sequencer, so the input closes behind it.
  a_busy_after_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i[1:0] == ACT_FILTER) |=> !s_axis_tready_o)
    else $error("input still open after a filter beat");

  // Coefficient writes produce no result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser_i[1:0] == ACT_WR_NUM || s_axis_tuser_i[1:0] == ACT_WR_DEN)
    && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("coefficient write produced a result");

  // When a new result appears the sequencer has already returned to idle.
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result appeared while the sequencer was busy");

endmodule

bind iir_direct_form_filter_core iirdf_checker u_iirdf_checker (.*);
